// File: design/imaenc_pkg.sv
package imaenc_pkg;

    localparam int unsigned MAX_INDEX  = 88;
    localparam int unsigned STEP_COUNT = MAX_INDEX + 1;

    typedef struct packed {
        logic [2:0]  channel;
        logic [11:0] raw_sample;
    } enc_in_t;

    typedef struct packed {
        logic [2:0]         out_channel;
        logic [3:0]         code_nibble;
        logic signed [15:0] predicted_sample;
        logic [6:0]         step_index;
    } enc_out_t;

    localparam logic [15:0] STEP_TABLE [0:STEP_COUNT-1] = '{
        16'd7,     16'd8,     16'd9,     16'd10,    16'd11,    16'd12,    16'd13,
        16'd14,    16'd16,    16'd17,    16'd19,    16'd21,    16'd23,    16'd25,
        16'd28,    16'd31,    16'd34,    16'd37,    16'd41,    16'd45,    16'd50,
        16'd55,    16'd60,    16'd66,    16'd73,    16'd80,    16'd88,    16'd97,
        16'd107,   16'd118,   16'd130,   16'd143,   16'd157,   16'd173,   16'd190,
        16'd209,   16'd230,   16'd253,   16'd279,   16'd307,   16'd337,   16'd371,
        16'd408,   16'd449,   16'd494,   16'd544,   16'd598,   16'd658,   16'd724,
        16'd796,   16'd876,   16'd963,   16'd1060,  16'd1166,  16'd1282,  16'd1411,
        16'd1552,  16'd1707,  16'd1878,  16'd2066,  16'd2272,  16'd2499,  16'd2749,
        16'd3024,  16'd3327,  16'd3660,  16'd4026,  16'd4428,  16'd4871,  16'd5358,
        16'd5894,  16'd6484,  16'd7132,  16'd7845,  16'd8630,  16'd9493,  16'd10442,
        16'd11487, 16'd12635, 16'd13899, 16'd15289, 16'd16818, 16'd18500, 16'd20350,
        16'd22385, 16'd24623, 16'd27086, 16'd29794, 16'd32767
    };

    // index change for a code magnitude
    function automatic logic signed [7:0] index_adjust(input logic [2:0] mag);
        logic signed [7:0] adj;
        begin
            unique case (mag)
                3'd4:    adj = 8'sd2;
                3'd5:    adj = 8'sd4;
                3'd6:    adj = 8'sd6;
                3'd7:    adj = 8'sd8;
                default: adj = -8'sd1;
            endcase
            return adj;
        end
    endfunction

endpackage

// File: design/multichannel_ima_adpcm_encoder.sv
// Channel   Direction  Handshake                    Word
// sample    in         sample_valid / sample_stall  enc_in_t  (channel, raw_sample)
// code      out        code_valid / code_stall      enc_out_t (channel, nibble, predictor, index)
//
// One word per cycle sustained while code_stall is low.
// All encoding sits between the input register and the result register, and the channel
// state is written back at the edge that loads the result, so the next word sees it.
// Reset clears all channel predictors and step indices at once (no clearing pass).
// A stalled result holds; a new sample word is still taken while the input register is free.
module multichannel_ima_adpcm_encoder
    import imaenc_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sample_valid,
    output logic     sample_stall,
    input  enc_in_t  sample_word,
    output logic     code_valid,
    input  logic     code_stall,
    output enc_out_t code_word
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // wide enough for both the channel field and the channel count itself
    localparam int EXT_W = (CH_W + 1 > 3) ? CH_W + 1 : 3;

    // input register
    enc_in_t  s1_word_reg;
    logic     s1_valid_reg;
    logic     s1_valid_next;

    // result register
    enc_out_t out_word_reg;
    logic     out_valid_reg;
    logic     out_valid_next;

    // per-channel state
    logic signed [15:0] pred_store_reg [CHANNELS];
    logic [6:0]         idx_store_reg  [CHANNELS];

    logic out_free;
    logic advance;
    logic load_s1;

    // encoder datapath
    logic [EXT_W-1:0]   ch_ext;
    logic [CH_W-1:0]    addr;
    logic               in_range;
    logic signed [15:0] pred_old;
    logic [6:0]         idx_old;
    logic [6:0]         idx_clip;
    logic [15:0]        step;
    logic [16:0]        step17;
    logic signed [15:0] sample;
    logic signed [16:0] diff;
    logic               neg;
    logic [16:0]        mag;
    logic [16:0]        rem1;
    logic [16:0]        rem2;
    logic               bit2;
    logic               bit1;
    logic               bit0;
    logic [16:0]        diffq;
    logic signed [17:0] pred_sum;
    logic signed [15:0] pred_new;
    logic signed [7:0]  idx_sum;
    logic [6:0]         idx_new;
    logic [3:0]         code;
    enc_out_t           result;

    assign out_free     = !out_valid_reg || !code_stall;
    assign advance      = s1_valid_reg && out_free;
    assign sample_stall = s1_valid_reg && !out_free;
    assign load_s1      = sample_valid && !sample_stall;

    assign code_valid = out_valid_reg;
    assign code_word  = out_word_reg;

    always_comb
    begin
        if (load_s1)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        // hold a stalled result, otherwise take whatever the input stage offers
        out_valid_next = out_free ? s1_valid_reg : 1'b1;
    end

    always_comb
    begin
        ch_ext   = EXT_W'(s1_word_reg.channel);
        addr     = ch_ext[CH_W-1:0];
        in_range = (ch_ext < EXT_W'(CHANNELS));

        // channels beyond the store start from a cleared state
        pred_old = in_range ? pred_store_reg[addr] : 16'sd0;
        idx_old  = in_range ? idx_store_reg[addr] : 7'd0;
        idx_clip = (idx_old > 7'(MAX_INDEX)) ? 7'(MAX_INDEX) : idx_old;
        step     = STEP_TABLE[idx_clip];
        step17   = {1'b0, step};

        // raw * 16 - 32768 is the sample with its top bit inverted
        sample = {~s1_word_reg.raw_sample[11], s1_word_reg.raw_sample[10:0], 4'b0000};

        diff = {sample[15], sample} - {pred_old[15], pred_old};
        neg  = diff[16];
        mag  = neg ? 17'(-diff) : 17'(diff);

        // three compare steps of the quantiser; the first two also subtract
        bit2 = (mag >= step17);
        rem1 = bit2 ? (mag - step17) : mag;
        bit1 = (rem1 >= (step17 >> 1));
        rem2 = bit1 ? (rem1 - (step17 >> 1)) : rem1;
        bit0 = (rem2 >= (step17 >> 2));
        code = {neg, bit2, bit1, bit0};

        diffq = (step17 >> 3)
              + (bit2 ? step17 : 17'd0)
              + (bit1 ? (step17 >> 1) : 17'd0)
              + (bit0 ? (step17 >> 2) : 17'd0);

        pred_sum = neg ? ({{2{pred_old[15]}}, pred_old} - $signed({1'b0, diffq}))
                       : ({{2{pred_old[15]}}, pred_old} + $signed({1'b0, diffq}));

        // saturate when the top three bits disagree
        if (pred_sum[17:15] == 3'b000 || pred_sum[17:15] == 3'b111)
        begin
            pred_new = pred_sum[15:0];
        end
        else if (pred_sum[17])
        begin
            pred_new = 16'sh8000;
        end
        else
        begin
            pred_new = 16'sh7fff;
        end

        idx_sum = $signed({1'b0, idx_clip}) + index_adjust(code[2:0]);
        if (idx_sum < 8'sd0)
        begin
            idx_new = 7'd0;
        end
        else if (idx_sum > 8'(MAX_INDEX))
        begin
            idx_new = 7'(MAX_INDEX);
        end
        else
        begin
            idx_new = idx_sum[6:0];
        end

        result.out_channel      = s1_word_reg.channel;
        result.code_nibble      = code;
        result.predicted_sample = pred_new;
        result.step_index       = idx_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: advance on handshake, hold otherwise
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_word_reg <= sample_word;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    // write back the channel state together with the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pred_store_reg[i] <= 16'sd0;
                idx_store_reg[i]  <= 7'd0;
            end
        end
        else if (advance && in_range)
        begin
            pred_store_reg[addr] <= pred_new;
            idx_store_reg[addr]  <= idx_new;
        end
    end

endmodule
